FILE: rtl/core/sbdc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SPI baud divider calculator.
// No dependencies; imported by sbdc_alu, sbdc_engine and spi_baud_divider_calc.
package sbdc_pkg;

   localparam int unsigned ALU_W = 48;

   localparam logic        REQ_TO_WORD = 1'b0;
   localparam logic        REQ_TO_FREQ = 1'b1;

   localparam logic [7:0]  PRESCALE_MIN = 8'd2;
   localparam logic [7:0]  PRESCALE_MAX = 8'd254;
   localparam logic [7:0]  POSTM1_MAX   = 8'd255;
   localparam logic [31:0] CLK_RESET    = 32'd125000000;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } sbdc_alu_op_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] target_freq;
      logic [15:0] packed_speed;
   } sbdc_cmd_type;

   typedef struct packed {
      logic [15:0] divider_word;
      logic [31:0] freq_hz;
      logic        bad_divider;
   } sbdc_res_type;

endpackage

FILE: rtl/core/spi_baud_divider_calc.sv
`timescale 1ns / 1ps
// Top level of the SPI baud divider calculator: handshakes, clock register, result register.
// Depends on sbdc_pkg and sbdc_engine (which uses sbdc_alu).
//
// Usage
//  - csr_ channel: one write beat loads the peripheral clock in hertz. Always ready.
//    Write it only while no request is in flight.
//  - req_ channel: one beat per request. req_type 0 turns a target frequency into a
//    divider word (prescale in bits 15..8, postdiv minus one in bits 7..0);
//    req_type 1 turns a divider word back into a frequency.
//  - rsp_ channel: one beat per request, held in an output register until taken.
//  - Sequence: a frequency-to-word request walks the prescale search (at most 127
//    steps) then the postdiv search (at most 256 steps), one step per cycle on the
//    shared adder. A word-to-frequency request is a multiply, then a 32-step
//    restoring division on the same adder; a zero prescale skips both and sets
//    bad_divider. One request is worked at a time; req_ready is high only while the
//    sequencer is idle.
//  - Stall: when rsp_ready is low, the finished beat holds in the output register;
//    the next request may still be accepted and computed, and its result waits in
//    the sequencer until the output register frees.
//  - Reset: clears the sequencer and output valid; the clock register returns to 125 MHz.
module spi_baud_divider_calc
   import sbdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_periph_clock_hz,
   // requests
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_target_freq,
   input  logic [15:0] req_packed_speed,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_divider_word,
   output logic [31:0] rsp_freq_hz,
   output logic        rsp_bad_divider
);

   logic [31:0]  clk_hz_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   sbdc_res_type rsp_ff, rsp_in;

   sbdc_cmd_type cmd;
   sbdc_res_type eng_res;
   logic         eng_res_valid;
   logic         eng_take;

   assign cmd.req_type     = req_type;
   assign cmd.target_freq  = req_target_freq;
   assign cmd.packed_speed = req_packed_speed;

   // clock register: plain load on each write beat
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= CLK_RESET;
      end else if (csr_valid && csr_ready) begin
         clk_hz_ff <= csr_periph_clock_hz;
      end
   end

   sbdc_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .start_valid_i (req_valid),
      .start_ready_o (req_ready),
      .cmd_i         (cmd),
      .clk_hz_i      (clk_hz_ff),
      .res_valid_o   (eng_res_valid),
      .res_take_i    (eng_take),
      .res_o         (eng_res)
   );

   // move a finished result into the output register whenever it is free or draining
   assign eng_take = eng_res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_divider_word = rsp_ff.divider_word;
   assign rsp_freq_hz      = rsp_ff.freq_hz;
   assign rsp_bad_divider  = rsp_ff.bad_divider;

`ifndef SYNTHESIS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result beat changed while stalled");

   a_take_needs_room: assert property (@(posedge clock) disable iff (reset)
      eng_take |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwrote an untaken beat");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      eng_take |=> rsp_valid_ff)
      else $error("result register did not load");
`endif

endmodule

FILE: rtl/core/sbdc_alu.sv
`timescale 1ns / 1ps
// Shared add/subtract unit used by the search and division steps of the sequencer.
// Depends on sbdc_pkg; bit ALU_W of the result is the carry or borrow.
module sbdc_alu
   import sbdc_pkg::*;
(
   input  logic [ALU_W-1:0] a_i,
   input  logic [ALU_W-1:0] b_i,
   input  sbdc_alu_op_type  op_i,
   output logic [ALU_W:0]   sum_o
);

   always_comb begin
      unique case (op_i)
         ALU_SUB: sum_o = {1'b0, a_i} - {1'b0, b_i};
         default: sum_o = {1'b0, a_i} + {1'b0, b_i};
      endcase
   end

endmodule

FILE: rtl/core/sbdc_engine.sv
`timescale 1ns / 1ps
// Sequencer for the divider searches and the serial frequency division.
// Depends on sbdc_pkg and sbdc_alu.
module sbdc_engine
   import sbdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start_valid_i,
   output logic         start_ready_o,
   input  sbdc_cmd_type cmd_i,
   input  logic [31:0]  clk_hz_i,
   output logic         res_valid_o,
   input  logic         res_take_i,
   output sbdc_res_type res_o
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_STEP,
      ST_SPAN,
      ST_POST,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic             req_ff, req_in;
   logic             bad_ff, bad_in;
   logic [31:0]      tgt_ff, tgt_in;
   logic [7:0]       pre_ff, pre_in;
   logic [7:0]       postm1_ff, postm1_in;
   logic [ALU_W-1:0] acc_ff, acc_in;
   logic [ALU_W-1:0] p_ff, p_in;
   logic [15:0]      dv_ff, dv_in;
   logic [15:0]      rem_ff, rem_in;
   logic [31:0]      qd_ff, qd_in;
   logic [4:0]       cnt_ff, cnt_in;

   logic [ALU_W-1:0] alu_a, alu_b;
   sbdc_alu_op_type  alu_op;
   logic [ALU_W:0]   alu_sum;
   logic             pre_hit, post_hit;
   logic [16:0]      div_prod;

   sbdc_alu u_alu (
      .a_i   (alu_a),
      .b_i   (alu_b),
      .op_i  (alu_op),
      .sum_o (alu_sum)
   );

   // clock < prescale*256*target, with acc holding prescale*target
   assign pre_hit  = {16'd0, clk_hz_i} < {acc_ff[39:0], 8'd0};
   // clock/(prescale*(postdiv-1)) > target  <=>  clock >= (target+1)*prescale*(postdiv-1)
   assign post_hit = {16'd0, clk_hz_i} >= p_ff;
   assign div_prod = {9'd0, pre_ff} * {8'd0, ({1'b0, postm1_ff} + 9'd1)};

   always_comb begin
      alu_a  = '0;
      alu_b  = '0;
      alu_op = ALU_ADD;
      case (state_ff)
         ST_PRE: begin
            alu_a = acc_ff;
            alu_b = {15'd0, tgt_ff, 1'b0};
         end
         ST_STEP: begin
            alu_a = acc_ff;
            alu_b = {40'd0, pre_ff};
         end
         ST_SPAN: begin
            alu_a  = {acc_ff[39:0], 8'd0};
            alu_b  = acc_ff;
            alu_op = ALU_SUB;
         end
         ST_POST: begin
            alu_a  = p_ff;
            alu_b  = acc_ff;
            alu_op = ALU_SUB;
         end
         ST_DIV: begin
            alu_a  = {31'd0, rem_ff, qd_ff[31]};
            alu_b  = {32'd0, dv_ff};
            alu_op = ALU_SUB;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      bad_in    = bad_ff;
      tgt_in    = tgt_ff;
      pre_in    = pre_ff;
      postm1_in = postm1_ff;
      acc_in    = acc_ff;
      p_in      = p_ff;
      dv_in     = dv_ff;
      rem_in    = rem_ff;
      qd_in     = qd_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_valid_i) begin
               req_in = cmd_i.req_type;
               tgt_in = cmd_i.target_freq;
               bad_in = 1'b0;
               if (cmd_i.req_type == REQ_TO_WORD) begin
                  pre_in   = PRESCALE_MIN;
                  acc_in   = {15'd0, cmd_i.target_freq, 1'b0};
                  state_in = ST_PRE;
               end else begin
                  pre_in    = cmd_i.packed_speed[15:8];
                  postm1_in = cmd_i.packed_speed[7:0];
                  if (cmd_i.packed_speed[15:8] == 8'd0) begin
                     bad_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_MUL;
                  end
               end
            end
         end
         ST_PRE: begin
            if (pre_hit || pre_ff == PRESCALE_MAX) begin
               state_in = ST_STEP;
            end else begin
               pre_in = pre_ff + 8'd2;
               acc_in = alu_sum[ALU_W-1:0];
            end
         end
         ST_STEP: begin
            acc_in   = alu_sum[ALU_W-1:0];
            state_in = ST_SPAN;
         end
         ST_SPAN: begin
            p_in      = alu_sum[ALU_W-1:0];
            postm1_in = POSTM1_MAX;
            state_in  = ST_POST;
         end
         ST_POST: begin
            if (postm1_ff == 8'd0 || post_hit) begin
               state_in = ST_DONE;
            end else begin
               p_in      = alu_sum[ALU_W-1:0];
               postm1_in = postm1_ff - 8'd1;
            end
         end
         ST_MUL: begin
            dv_in    = div_prod[15:0];
            rem_in   = '0;
            qd_in    = clk_hz_i;
            cnt_in   = 5'd31;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!alu_sum[ALU_W]) begin
               rem_in = alu_sum[15:0];
               qd_in  = {qd_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[14:0], qd_ff[31]};
               qd_in  = {qd_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_take_i) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff    <= req_in;
      bad_ff    <= bad_in;
      tgt_ff    <= tgt_in;
      pre_ff    <= pre_in;
      postm1_ff <= postm1_in;
      acc_ff    <= acc_in;
      p_ff      <= p_in;
      dv_ff     <= dv_in;
      rem_ff    <= rem_in;
      qd_ff     <= qd_in;
      cnt_ff    <= cnt_in;
   end

   assign start_ready_o = (state_ff == ST_IDLE);
   assign res_valid_o   = (state_ff == ST_DONE);

   always_comb begin
      res_o = '0;
      if (req_ff == REQ_TO_WORD) begin
         res_o.divider_word = {pre_ff, postm1_ff};
      end else if (bad_ff) begin
         res_o.bad_divider = 1'b1;
      end else if (&qd_ff) begin
         res_o.freq_hz = '1;
      end else begin
         res_o.freq_hz = qd_ff + 32'd1;
      end
   end

`ifndef SYNTHESIS
   a_pre_even: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PRE |-> !pre_ff[0] && pre_ff >= PRESCALE_MIN)
      else $error("prescale left the even range during search");

   a_word_prescale: assert property (@(posedge clock) disable iff (reset)
      res_valid_o && req_ff == REQ_TO_WORD |-> !res_o.divider_word[8]
         && res_o.divider_word[15:8] >= PRESCALE_MIN)
      else $error("divider word carries an invalid prescale");

   a_bad_only_freq: assert property (@(posedge clock) disable iff (reset)
      res_valid_o && res_o.bad_divider |-> req_ff == REQ_TO_FREQ && res_o.freq_hz == 32'd0)
      else $error("error flag raised outside a zero-prescale request");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid_o && res_take_i |=> state_ff == ST_IDLE)
      else $error("engine did not release after result beat");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> dv_ff != 16'd0)
      else $error("serial divider running with zero divisor");
`endif

endmodule
